// ===== hdl/afhp_pkg.sv =====
package afhp_pkg;

  localparam int unsigned MaxDigis = 8;
  localparam int unsigned MaxInfo  = 256;
  localparam int unsigned AddrBytes = 7;
  localparam int unsigned MinFrame = 15;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    KIND_DEST = 3'd0,
    KIND_SRC  = 3'd1,
    KIND_DIGI = 3'd2,
    KIND_CTRL = 3'd3,
    KIND_PID  = 3'd4,
    KIND_PAY  = 3'd5,
    KIND_DROP = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_NO_CTRL = 2'd2,
    ST_NO_PID  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FT_I  = 2'd0,
    FT_S  = 2'd1,
    FT_U  = 2'd2,
    FT_UI = 2'd3
  } ftype_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [8:0] frame_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] field_kind;
    logic [3:0] address_slot;
    logic [7:0] offset_in_field;
    logic       frame_done;
    logic [1:0] status;
    logic [1:0] frame_type;
    logic       cmd_flag;
    logic [3:0] digipeater_count;
    logic [8:0] payload_length;
    logic [2:0] send_seq;
    logic [2:0] recv_seq;
  } out_item_t;

  // tagged byte handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] kind;
    logic [3:0] slot;
    logic [7:0] offset;
    logic       done;
    logic [1:0] status;
    logic [7:0] control;
    logic       command;
    logic [3:0] digis;
    logic [8:0] payload;
  } tag_t;

  function automatic logic [1:0] classify(input logic [7:0] c);
    logic [1:0] r;
    if (c[0] == 1'b0) r = FT_I;
    else if (c[1] == 1'b0) r = FT_S;
    else if ((c & 8'hEF) == 8'h03) r = FT_UI;
    else r = FT_U;
    return r;
  endfunction

endpackage

// ===== hdl/afhp_front.sv =====
module afhp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  afhp_pkg::in_item_t item_i,
  output logic               push_o,
  output afhp_pkg::tag_t     tag_o,
  input  logic               full_i
);

  logic [8:0] pos_q, pos_d;
  logic [8:0] len_q, len_d;
  logic [2:0] field_q, field_d;
  logic [3:0] slot_q, slot_d;
  logic [2:0] aoff_q, aoff_d;
  logic       last_q, last_d;
  logic [3:0] digi_q, digi_d;
  logic [7:0] ctrl_q, ctrl_d;
  logic       cmd_q, cmd_d;
  logic [8:0] pay_q, pay_d;

  logic [8:0] len;
  logic [2:0] field;
  logic [3:0] slot, digi;
  logic [2:0] aoff;
  logic       lastb, cmd, done, fire;
  logic [7:0] ctrl;
  logic [8:0] pay;
  logic [9:0] need;

  assign ready_o = !full_i;
  assign fire    = valid_i && ready_o;

  // first byte of a frame starts from a clean state
  always_comb begin
    if (pos_q == 9'd0) begin
      len   = (item_i.frame_len == 9'd0) ? 9'd1 : item_i.frame_len;
      field = afhp_pkg::KIND_DEST;
      slot  = 4'd0;
      aoff  = 3'd0;
      lastb = 1'b0;
      digi  = 4'd0;
      ctrl  = 8'd0;
      cmd   = 1'b0;
      pay   = 9'd0;
    end else begin
      len   = len_q;
      field = field_q;
      slot  = slot_q;
      aoff  = aoff_q;
      lastb = last_q;
      digi  = digi_q;
      ctrl  = ctrl_q;
      cmd   = cmd_q;
      pay   = pay_q;
    end
  end

  assign done = ({1'b0, pos_q} + 10'd1) >= {1'b0, len};
  assign need = {1'b0, pos_q} + 10'd1 + 10'(afhp_pkg::AddrBytes);

  // byte classification and state update
  always_comb begin
    tag_o = '0;
    tag_o.data_byte = item_i.data_byte;
    tag_o.kind = afhp_pkg::KIND_DROP;
    tag_o.done = done;
    field_d = field;
    slot_d  = slot;
    aoff_d  = aoff;
    last_d  = lastb;
    digi_d  = digi;
    ctrl_d  = ctrl;
    cmd_d   = cmd;
    pay_d   = pay;
    if (len < 9'(afhp_pkg::MinFrame)) begin
      tag_o.kind = afhp_pkg::KIND_DROP;
    end else if (field == afhp_pkg::KIND_DEST || field == afhp_pkg::KIND_SRC ||
                 field == afhp_pkg::KIND_DIGI) begin
      tag_o.kind = field;
      tag_o.slot = (field == afhp_pkg::KIND_DEST) ? 4'd0 :
                   (field == afhp_pkg::KIND_SRC) ? 4'd1 : slot;
      tag_o.offset = {5'd0, aoff};
      if (aoff == 3'(afhp_pkg::AddrBytes - 1)) begin
        aoff_d = 3'd0;
        if (field == afhp_pkg::KIND_DEST) begin
          cmd_d   = item_i.data_byte[7];
          field_d = afhp_pkg::KIND_SRC;
        end else begin
          last_d = item_i.data_byte[0];
          if (!item_i.data_byte[0] && digi < 4'(afhp_pkg::MaxDigis) &&
              need <= {1'b0, len}) begin
            field_d = afhp_pkg::KIND_DIGI;
            slot_d  = digi + 4'd2;
            digi_d  = digi + 4'd1;
          end else begin
            field_d = afhp_pkg::KIND_CTRL;
          end
        end
      end else begin
        aoff_d = aoff + 3'd1;
      end
    end else if (field == afhp_pkg::KIND_CTRL) begin
      tag_o.kind = afhp_pkg::KIND_CTRL;
      ctrl_d = item_i.data_byte;
      field_d = (afhp_pkg::classify(item_i.data_byte) == afhp_pkg::FT_I ||
                 afhp_pkg::classify(item_i.data_byte) == afhp_pkg::FT_UI) ?
                afhp_pkg::KIND_PID : afhp_pkg::KIND_PAY;
    end else if (field == afhp_pkg::KIND_PID) begin
      tag_o.kind = afhp_pkg::KIND_PID;
      field_d = afhp_pkg::KIND_PAY;
    end else begin
      if (pay < 9'(afhp_pkg::MaxInfo)) begin
        tag_o.kind = afhp_pkg::KIND_PAY;
        tag_o.offset = pay[8] ? 8'd255 : pay[7:0];
        pay_d = pay + 9'd1;
      end
    end
    // end-of-frame summary
    if (done) begin
      if (len < 9'(afhp_pkg::MinFrame)) tag_o.status = afhp_pkg::ST_SHORT;
      else if (field == afhp_pkg::KIND_DEST || field == afhp_pkg::KIND_SRC ||
               field == afhp_pkg::KIND_DIGI) tag_o.status = afhp_pkg::ST_NO_CTRL;
      else if (field == afhp_pkg::KIND_CTRL && field_d == afhp_pkg::KIND_PID)
        tag_o.status = afhp_pkg::ST_NO_PID;
      else tag_o.status = afhp_pkg::ST_OK;
      tag_o.control = ctrl_d;
      tag_o.command = cmd_d;
      tag_o.digis   = digi_d;
      tag_o.payload = pay_d;
    end
  end

  assign push_o = fire;

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; len_q <= '0; field_q <= afhp_pkg::KIND_DEST; slot_q <= '0;
      aoff_q <= '0; last_q <= 1'b0; digi_q <= '0; ctrl_q <= '0; cmd_q <= 1'b0;
      pay_q <= '0;
    end else if (fire) begin
      if (done) begin
        pos_q <= '0;
      end else begin
        pos_q <= pos_q + 9'd1;
      end
      len_q <= len; field_q <= field_d; slot_q <= slot_d; aoff_q <= aoff_d;
      last_q <= last_d; digi_q <= digi_d; ctrl_q <= ctrl_d; cmd_q <= cmd_d;
      pay_q <= pay_d;
    end
  end

endmodule

// ===== hdl/afhp_back.sv =====
module afhp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  afhp_pkg::tag_t      tag_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                ready_i,
  output afhp_pkg::out_item_t item_o
);

  afhp_pkg::tag_t mem_q [afhp_pkg::QueueDepth];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       pop;
  afhp_pkg::tag_t h;

  assign full_o  = (cnt_q == 2'(afhp_pkg::QueueDepth));
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign h       = mem_q[rptr_q];

  // result formatting from queue head
  always_comb begin
    item_o = '0;
    item_o.byte_out        = h.data_byte;
    item_o.field_kind      = h.kind;
    item_o.address_slot    = h.slot;
    item_o.offset_in_field = h.offset;
    item_o.frame_done      = h.done;
    item_o.status          = h.status;
    if (h.done && h.status == afhp_pkg::ST_OK) begin
      item_o.frame_type       = afhp_pkg::classify(h.control);
      item_o.cmd_flag         = h.command;
      item_o.digipeater_count = h.digis;
      item_o.payload_length   = h.payload;
      item_o.send_seq         = h.control[3:1];
      item_o.recv_seq         = h.control[7:5];
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= tag_i;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0; rptr_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/ax25_frame_header_parser.sv =====
// AX.25 header tagger: one frame byte is accepted per clock while the queue is not full, and
// one tagged result leaves per byte, each registered in a two-entry queue that separates the
// classifying front from the output, so a byte offered during an output stall is still taken
// in, after which intake pauses until the output takes a result. Frame length is sampled on
// each frame's first byte; the final byte carries the frame summary.
module ax25_frame_header_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  afhp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output afhp_pkg::out_item_t out_item_o
);

  logic           push, full;
  afhp_pkg::tag_t tag;

  afhp_front u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .ready_o(in_ready_o), .item_i(in_item_i),
    .push_o(push), .tag_o(tag), .full_i(full)
  );

  afhp_back u_back (
    .clk_i, .rst_ni, .push_i(push), .tag_i(tag), .full_o(full),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .item_o(out_item_o)
  );

endmodule

// ===== hdl/afhp_checker.sv =====
module afhp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input afhp_pkg::out_item_t out_item_o
);

  // an accepted byte makes the output valid in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o) else $error("result missing");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // summary only on last byte
  a_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.frame_done |-> out_item_o.status == afhp_pkg::ST_OK &&
    out_item_o.payload_length == 9'd0) else $error("summary on inner byte");

  // intake open while the queue is empty
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("stall with empty queue");

endmodule

bind ax25_frame_header_parser afhp_checker u_checker (.*);
